// File: src/sine_bell_smoother_edge_extrapolate_unit_macros.svh
// Assertion helpers used by the checker of this block.
`ifndef SINE_BELL_SMOOTHER_EDGE_EXTRAPOLATE_UNIT_MACROS_SVH
`define SINE_BELL_SMOOTHER_EDGE_EXTRAPOLATE_UNIT_MACROS_SVH

// same-cycle implication
`define SBSE_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sbse assertion failed: same-cycle implication");

// next-cycle implication
`define SBSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sbse assertion failed: next-cycle implication");

`endif

// File: src/sbse_pkg.sv
package sbse_pkg;

  localparam int HALF_WIDTH = 8;
  localparam int MAX_SPAN   = 16;
  localparam int TAPS       = 2 * HALF_WIDTH + 1;
  localparam int HELD       = MAX_SPAN + 1;

  localparam int SAMPLE_W   = 16;
  localparam int SPAN_W     = 5;
  localparam int COUNT_W    = 16;
  localparam int TAP_IDX_W  = $clog2(TAPS);
  localparam int HELD_IDX_W = $clog2(HELD);
  localparam int HC_W       = $clog2(HELD + 1);
  localparam int K_W        = $clog2(HALF_WIDTH + 1);

  localparam int COEF_W     = 16;
  localparam int PROD_W     = SAMPLE_W + COEF_W + 1;
  localparam int ACC_W      = PROD_W + TAP_IDX_W;
  localparam int NUM_W      = SAMPLE_W + K_W;
  localparam int WIDE_W     = 24;

  localparam logic [SPAN_W-1:0] SPAN_RESET = SPAN_W'(4);

  typedef logic [COEF_W-1:0] coef_t;

  // sine-bell taps, Q0.16, normalised to unit sum; symmetric about the centre
  localparam coef_t COEF_ROM [TAPS] = '{
    16'd996,  16'd1961, 16'd2867, 16'd3686, 16'd4392, 16'd4965, 16'd5388, 16'd5647,
    16'd5734,
    16'd5647, 16'd5388, 16'd4965, 16'd4392, 16'd3686, 16'd2867, 16'd1961, 16'd996
  };

  typedef struct packed {
    logic clear;
    logic en;
  } mac_ctrl_t;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [SPAN_W-1:0] den;
  } div_req_t;

  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'(2 ** (SAMPLE_W - 1) - 1);
    lo = -hi - WIDE_W'(1);
    if (v > hi) begin
      return hi[SAMPLE_W-1:0];
    end else if (v < lo) begin
      return lo[SAMPLE_W-1:0];
    end
    return v[SAMPLE_W-1:0];
  endfunction

endpackage

// File: src/sbse_mac.sv
module sbse_mac import sbse_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  mac_ctrl_t                  ctrl,
  input  coef_t                      coef,
  input  logic signed [SAMPLE_W-1:0] smp,
  output logic signed [SAMPLE_W-1:0] y
);

  logic signed [PROD_W-1:0] prod;
  logic                     prod_v;
  logic signed [ACC_W-1:0]  acc;

  // product registered, then summed
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_v <= 1'b0;
    end else begin
      prod_v <= ctrl.en;
    end
    prod <= $signed({1'b0, coef}) * smp;
    if (ctrl.clear) begin
      acc <= ACC_W'(2 ** (COEF_W - 1));
    end else if (prod_v) begin
      acc <= acc + {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  assign y = sat16(WIDE_W'(acc >>> COEF_W));

endmodule

// File: src/sbse_div.sv
module sbse_div import sbse_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [NUM_W-1:0]  num_sh;
  logic [SPAN_W-1:0] rem;
  logic [SPAN_W-1:0] den;
  logic [SPAN_W-1:0] rem_sh;
  logic              ge;

  // remainder stays below the divisor, so its top bit is free for the shift
  assign rem_sh = {rem[SPAN_W-2:0], num_sh[NUM_W-1]};
  assign ge     = rem_sh >= den;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy   <= 1'b1;
        cnt    <= CNT_W'(NUM_W);
        num_sh <= req.num;
        rem    <= '0;
        den    <= req.den;
      end else if (busy) begin
        rem    <= ge ? rem_sh - den : rem_sh;
        num_sh <= {num_sh[NUM_W-2:0], ge};
        cnt    <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = num_sh;

endmodule

// File: src/sine_bell_smoother_edge_extrapolate_unit.sv
// Sine-bell smoother with linear edge extrapolation. Samples of a frame go in one item at a
// time on the input channel; the frame ends at an item with frame_end set. Once 17 samples
// are in, each item yields one 17-tap windowed output, formed by a single multiply-accumulate
// unit stepping over the taps; an item also waits for the output register when the far side
// stalls. Interior outputs are held back until the span register (span, read when an item
// is accepted; 0 acts as 1, above 16 as 16) allows the slope at the leading edge; that item
// then sends eight extrapolated outputs and every held one. Each extrapolated output, the
// eight leading and the eight trailing ones at frame end, runs through a shared 20-step
// restoring divider. A frame that ends before the leading edge went out gives one item with
// too_short and out_last set. in_stall is high for the whole of an item's work.
module sine_bell_smoother_edge_extrapolate_unit import sbse_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       frame_end,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] smoothed,
  output logic                       out_last,
  output logic                       too_short,
  input  logic                       cfg_wen,
  input  logic [SPAN_W-1:0]          cfg_wdata
);

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_MAC, S_DRAIN, S_PUSH, S_EMIT_Y, S_LEAD_CHK,
    S_RD_A, S_RD_B, S_RD_C, S_DIV, S_DIV_WAIT, S_EXT_EMIT,
    S_HRD, S_HEMIT, S_END_CHK, S_ERR, S_CLEAR
  } state_t;

  state_t state;

  // frame state
  logic signed [SAMPLE_W-1:0] win  [TAPS];
  logic signed [SAMPLE_W-1:0] held [HELD];
  logic [COUNT_W-1:0]         count;
  logic                       start_em;
  logic                       is_end;
  logic [SPAN_W-1:0]          span;
  logic [SPAN_W-1:0]          m;
  logic [HC_W-1:0]            hc;

  // sequencer working registers
  logic [TAP_IDX_W-1:0]       mac_idx;
  logic [HELD_IDX_W-1:0]      rd_addr;
  logic [HELD_IDX_W-1:0]      oth_idx;
  logic [HELD_IDX_W-1:0]      j;
  logic signed [SAMPLE_W-1:0] held_q;
  logic signed [SAMPLE_W-1:0] base;
  logic signed [SAMPLE_W:0]   dval;
  logic [K_W-1:0]             kk;
  logic                       trail;
  logic [SPAN_W-1:0]          den;
  logic signed [SAMPLE_W-1:0] ext;

  mac_ctrl_t                  mac_ctrl;
  logic signed [SAMPLE_W-1:0] mac_y;
  div_req_t                   div_req;
  logic                       div_done;
  logic [NUM_W-1:0]           quo;

  logic                       emit_ok;
  logic                       emit_now;
  logic [COUNT_W-1:0]         excess;
  logic [HC_W-1:0]            hc_calc;
  logic [SPAN_W-1:0]          m_in;
  logic [HC_W-1:0]            hcm1;
  logic [SPAN_W-1:0]          me;
  logic [SAMPLE_W:0]          dabs;
  logic signed [WIDE_W-1:0]   qs;
  logic signed [WIDE_W-1:0]   ext_sum;

  sbse_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mac_ctrl),
    .coef (COEF_ROM[mac_idx]),
    .smp  (win[mac_idx]),
    .y    (mac_y)
  );

  sbse_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quo  (quo)
  );

  assign in_stall = (state != S_IDLE);
  // output register free, or emptied at this edge
  assign emit_ok  = !out_valid || !out_stall;
  // an item enters the output register at this edge
  assign emit_now = (state inside {S_EMIT_Y, S_EXT_EMIT, S_HEMIT, S_ERR}) && emit_ok;

  assign mac_ctrl.clear = (state == S_CHECK);
  assign mac_ctrl.en    = (state == S_MAC);

  // interior outputs so far, capped at the held depth
  assign excess  = count - COUNT_W'(TAPS - 1);
  assign hc_calc = (excess > COUNT_W'(HELD)) ? HC_W'(HELD) : excess[HC_W-1:0];

  assign m_in = (span == '0) ? SPAN_W'(1) :
                (span > SPAN_W'(MAX_SPAN)) ? SPAN_W'(MAX_SPAN) : span;

  // trailing span never reaches past the oldest held output
  assign hcm1 = hc - 1'b1;
  assign me   = (m < SPAN_W'(hcm1)) ? m : SPAN_W'(hcm1);

  assign dabs = dval[SAMPLE_W] ? -dval : dval;

  assign div_req.start = (state == S_DIV);
  assign div_req.num   = NUM_W'(kk) * NUM_W'(dabs[SAMPLE_W-1:0]);
  assign div_req.den   = den;

  // quotient takes the sign of the slope; truncation toward zero is symmetric
  always_comb begin
    qs = $signed(WIDE_W'(quo));
    if (dval[SAMPLE_W]) begin
      qs = -qs;
    end
    ext_sum = {{(WIDE_W - SAMPLE_W){base[SAMPLE_W-1]}}, base} + qs;
  end

  always_ff @(posedge clk) begin
    held_q <= held[rd_addr];
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      start_em  <= 1'b0;
      span      <= SPAN_RESET;
      out_valid <= 1'b0;
      for (int i = 0; i < TAPS; i++) begin
        win[i] <= '0;
      end
    end else begin
      if (cfg_wen) begin
        span <= cfg_wdata;
      end
      out_valid <= emit_now || (out_valid && out_stall);

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            for (int i = TAPS - 1; i > 0; i--) begin
              win[i] <= win[i-1];
            end
            win[0] <= sample;
            if (count != '1) begin
              count <= count + 1'b1;
            end
            is_end <= frame_end;
            m      <= m_in;
            state  <= S_CHECK;
          end
        end

        S_CHECK: begin
          if (count >= COUNT_W'(TAPS)) begin
            mac_idx <= '0;
            state   <= S_MAC;
          end else begin
            hc    <= '0;
            state <= S_LEAD_CHK;
          end
        end

        S_MAC: begin
          if (mac_idx == TAP_IDX_W'(TAPS - 1)) begin
            state <= S_DRAIN;
          end else begin
            mac_idx <= mac_idx + 1'b1;
          end
        end

        S_DRAIN: state <= S_PUSH;

        S_PUSH: begin
          for (int i = HELD - 1; i > 0; i--) begin
            held[i] <= held[i-1];
          end
          held[0] <= mac_y;
          hc      <= hc_calc;
          state   <= start_em ? S_EMIT_Y : S_LEAD_CHK;
        end

        S_EMIT_Y: begin
          if (emit_ok) begin
            smoothed  <= mac_y;
            out_last  <= 1'b0;
            too_short <= 1'b0;
            state     <= S_LEAD_CHK;
          end
        end

        S_LEAD_CHK: begin
          if (!start_em && ({1'b0, hc} >= {1'b0, m} + 1'b1)) begin
            rd_addr <= HELD_IDX_W'(hcm1);
            oth_idx <= HELD_IDX_W'(hcm1 - HC_W'(m));
            den     <= m;
            kk      <= K_W'(HALF_WIDTH);
            trail   <= 1'b0;
            state   <= S_RD_A;
          end else begin
            state <= S_END_CHK;
          end
        end

        S_RD_A: begin
          rd_addr <= oth_idx;
          state   <= S_RD_B;
        end

        S_RD_B: begin
          base  <= held_q;
          state <= S_RD_C;
        end

        S_RD_C: begin
          dval  <= {base[SAMPLE_W-1], base} - {held_q[SAMPLE_W-1], held_q};
          state <= S_DIV;
        end

        S_DIV: state <= S_DIV_WAIT;

        S_DIV_WAIT: begin
          if (div_done) begin
            ext   <= sat16(ext_sum);
            state <= S_EXT_EMIT;
          end
        end

        S_EXT_EMIT: begin
          if (emit_ok) begin
            smoothed  <= ext;
            out_last  <= trail && (kk == K_W'(HALF_WIDTH));
            too_short <= 1'b0;
            if (trail) begin
              if (kk == K_W'(HALF_WIDTH)) begin
                state <= S_CLEAR;
              end else begin
                kk    <= kk + 1'b1;
                state <= S_DIV;
              end
            end else if (kk == K_W'(1)) begin
              j       <= HELD_IDX_W'(hcm1);
              rd_addr <= HELD_IDX_W'(hcm1);
              state   <= S_HRD;
            end else begin
              kk    <= kk - 1'b1;
              state <= S_DIV;
            end
          end
        end

        S_HRD: state <= S_HEMIT;

        // held outputs go out oldest first
        S_HEMIT: begin
          if (emit_ok) begin
            smoothed  <= held_q;
            out_last  <= 1'b0;
            too_short <= 1'b0;
            if (j == '0) begin
              start_em <= 1'b1;
              state    <= S_END_CHK;
            end else begin
              j       <= j - 1'b1;
              rd_addr <= j - 1'b1;
              state   <= S_HRD;
            end
          end
        end

        S_END_CHK: begin
          if (!is_end) begin
            state <= S_IDLE;
          end else if (start_em) begin
            rd_addr <= '0;
            oth_idx <= HELD_IDX_W'(me);
            den     <= me;
            kk      <= K_W'(1);
            trail   <= 1'b1;
            state   <= S_RD_A;
          end else begin
            state <= S_ERR;
          end
        end

        S_ERR: begin
          if (emit_ok) begin
            smoothed  <= '0;
            out_last  <= 1'b1;
            too_short <= 1'b1;
            state     <= S_CLEAR;
          end
        end

        S_CLEAR: begin
          count    <= '0;
          start_em <= 1'b0;
          for (int i = 0; i < TAPS; i++) begin
            win[i] <= '0;
          end
          state <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: src/sbse_checker.sv
`include "sine_bell_smoother_edge_extrapolate_unit_macros.svh"

module sbse_checker import sbse_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic signed [SAMPLE_W-1:0] smoothed,
  input logic                       out_last,
  input logic                       too_short
);

  // error item is a zero closing the frame
  `SBSE_ASSERT_IMPL(a_err_item, clk, rst, out_valid && too_short, out_last && smoothed == '0)
  // busy right after taking an item
  `SBSE_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  `SBSE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  `SBSE_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall,
                    $stable(smoothed) && $stable(out_last) && $stable(too_short))

endmodule

bind sine_bell_smoother_edge_extrapolate_unit sbse_checker u_sbse_checker (.*);
